FILE: hw/rtl/rmr_pkg.sv
// Shared constants and codes for the rational multiply/reduce block.
`timescale 1ns / 1ps

package rmr_pkg;

    // Width of the stored fraction.
    localparam int WIDTH = 32;
    // Width of the operand and result ports.
    localparam int IO_W  = 32;
    // Full product of a stored part and an operand.
    localparam int PROD_W = WIDTH + IO_W;
    // Shared subtractor: one guard bit for the divider shift, one for the borrow.
    localparam int ALU_W = WIDTH + 2;
    // Counter for divider steps and the common power of two.
    localparam int CNT_W = $clog2(WIDTH);

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_MUL    = 2'd1,
        OP_REDUCE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_ZERO_DEN = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

endpackage

FILE: hw/rtl/rational_multiply_reduce_core.sv
// Top level: stored signed fraction with load, multiply and gcd reduction.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------
//  in      | in        | in_valid / in_stall  | op, operand_top, operand_bottom
//  out     | out       | out_valid / out_stall| value_top, value_bottom, status
//
//  From acceptance to the result: load and the unused op go straight to the done state;
//  multiply forms the numerator and then the denominator product on one shared multiplier.
//  Reduce takes both magnitudes, checks for zero, runs one binary-gcd step per cycle, then
//  two bit-serial divisions, each with a sign fix; these steps share one subtractor.
//  in_stall is high from acceptance until the result is loaded into the output register.
//  rst_n clears the fraction to 0/1; a stalled result holds and the block waits.
`timescale 1ns / 1ps

module rational_multiply_reduce_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       op,
    input  logic signed [rmr_pkg::IO_W-1:0]  operand_top,
    input  logic signed [rmr_pkg::IO_W-1:0]  operand_bottom,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [rmr_pkg::IO_W-1:0]  value_top,
    output logic signed [rmr_pkg::IO_W-1:0]  value_bottom,
    output logic [1:0]                       status
);

    localparam int W = rmr_pkg::WIDTH;
    localparam logic [rmr_pkg::CNT_W-1:0] CNT_LAST = rmr_pkg::CNT_W'(W - 1);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_MUL_TOP = 11'b000_0000_0010,
        S_MUL_BOT = 11'b000_0000_0100,
        S_MUL_END = 11'b000_0000_1000,
        S_MAG_TOP = 11'b000_0001_0000,
        S_MAG_BOT = 11'b000_0010_0000,
        S_CHECK   = 11'b000_0100_0000,
        S_GCD     = 11'b000_1000_0000,
        S_DIV     = 11'b001_0000_0000,
        S_NEG     = 11'b010_0000_0000,
        S_DONE    = 11'b100_0000_0000
    } state_t;

    state_t                          state_reg, state_next;
    logic signed [W-1:0]             frac_top_reg, frac_top_next;
    logic signed [W-1:0]             frac_bot_reg, frac_bot_next;
    logic                            out_valid_reg, out_valid_next;
    logic [rmr_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [rmr_pkg::CNT_W-1:0]       k_reg, k_next;
    logic                            second_reg, second_next;

    logic signed [rmr_pkg::IO_W-1:0] opt_reg, opt_next;
    logic signed [rmr_pkg::IO_W-1:0] opb_reg, opb_next;
    logic signed [rmr_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [W-1:0]                    mt_reg, mt_next;
    logic [W-1:0]                    mb_reg, mb_next;
    logic [W-1:0]                    gx_reg, gx_next;
    logic [W-1:0]                    gy_reg, gy_next;
    logic [W-1:0]                    d_reg, d_next;
    logic [W-1:0]                    rem_reg, rem_next;
    logic [W-1:0]                    q_reg, q_next;
    rmr_pkg::status_t                status_reg, status_next;
    logic signed [rmr_pkg::IO_W-1:0] out_top_reg, out_top_next;
    logic signed [rmr_pkg::IO_W-1:0] out_bot_reg, out_bot_next;
    rmr_pkg::status_t                out_status_reg, out_status_next;

    logic                            in_accept;
    logic signed [W-1:0]             ld_top, ld_bot;
    logic signed [W-1:0]             mul_a;
    logic signed [rmr_pkg::IO_W-1:0] mul_b;
    logic                            prod_fits;
    logic [rmr_pkg::ALU_W-1:0]       alu_a, alu_b, alu_diff;
    logic                            alu_borrow;
    logic [W-1:0]                    neg_result;
    logic                            neg_sign;

    assign in_stall     = (state_reg != S_IDLE);
    assign in_accept    = in_valid && !in_stall;
    assign out_valid    = out_valid_reg;
    assign value_top    = out_top_reg;
    assign value_bottom = out_bot_reg;
    assign status       = out_status_reg;

    assign ld_top = W'(operand_top);
    assign ld_bot = W'(operand_bottom);

    // Shared multiplier: numerator first, denominator next.
    assign mul_a     = (state_reg == S_MUL_TOP) ? frac_top_reg : frac_bot_reg;
    assign mul_b     = (state_reg == S_MUL_TOP) ? opt_reg : opb_reg;
    assign prod_fits = (&prod_reg[rmr_pkg::PROD_W-1:W-1]) || !(|prod_reg[rmr_pkg::PROD_W-1:W-1]);

    // Shared subtractor operands.
    always_comb
    begin
        alu_a = '0;
        alu_b = '0;
        case (state_reg)
            S_MAG_TOP:
            begin
                alu_b = {2'b00, frac_top_reg};
            end
            S_MAG_BOT:
            begin
                alu_b = {2'b00, frac_bot_reg};
            end
            S_GCD:
            begin
                alu_a = {2'b00, gx_reg};
                alu_b = {2'b00, gy_reg};
            end
            S_DIV:
            begin
                alu_a = {1'b0, rem_reg, q_reg[W-1]};
                alu_b = {2'b00, d_reg};
            end
            S_NEG:
            begin
                alu_b = {2'b00, q_reg};
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    assign alu_diff   = alu_a - alu_b;
    assign alu_borrow = alu_diff[rmr_pkg::ALU_W-1];

    assign neg_sign   = second_reg ? frac_bot_reg[W-1] : frac_top_reg[W-1];
    assign neg_result = neg_sign ? alu_diff[W-1:0] : q_reg;

    always_comb
    begin
        state_next      = state_reg;
        frac_top_next   = frac_top_reg;
        frac_bot_next   = frac_bot_reg;
        out_valid_next  = out_valid_reg;
        cnt_next        = cnt_reg;
        k_next          = k_reg;
        second_next     = second_reg;
        opt_next        = opt_reg;
        opb_next        = opb_reg;
        prod_next       = prod_reg;
        mt_next         = mt_reg;
        mb_next         = mb_reg;
        gx_next         = gx_reg;
        gy_next         = gy_reg;
        d_next          = d_reg;
        rem_next        = rem_reg;
        q_next          = q_reg;
        status_next     = status_reg;
        out_top_next    = out_top_reg;
        out_bot_next    = out_bot_reg;
        out_status_next = out_status_reg;

        // Drop the result once taken.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    opt_next    = operand_top;
                    opb_next    = operand_bottom;
                    status_next = rmr_pkg::STATUS_OK;
                    case (op)
                        rmr_pkg::OP_LOAD:
                        begin
                            if (ld_bot == '0)
                            begin
                                status_next = rmr_pkg::STATUS_ZERO_DEN;
                            end
                            else
                            begin
                                frac_top_next = ld_top;
                                frac_bot_next = ld_bot;
                            end
                            state_next = S_DONE;
                        end
                        rmr_pkg::OP_MUL:
                        begin
                            state_next = S_MUL_TOP;
                        end
                        rmr_pkg::OP_REDUCE:
                        begin
                            state_next = S_MAG_TOP;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_MUL_TOP:
            begin
                prod_next  = mul_a * mul_b;
                state_next = S_MUL_BOT;
            end
            S_MUL_BOT:
            begin
                frac_top_next = prod_reg[W-1:0];
                if (!prod_fits)
                begin
                    status_next = rmr_pkg::STATUS_OVERFLOW;
                end
                prod_next  = mul_a * mul_b;
                state_next = S_MUL_END;
            end
            S_MUL_END:
            begin
                frac_bot_next = prod_reg[W-1:0];
                if (!prod_fits)
                begin
                    status_next = rmr_pkg::STATUS_OVERFLOW;
                end
                state_next = S_DONE;
            end
            S_MAG_TOP:
            begin
                mt_next    = frac_top_reg[W-1] ? alu_diff[W-1:0] : frac_top_reg;
                gx_next    = mt_next;
                state_next = S_MAG_BOT;
            end
            S_MAG_BOT:
            begin
                mb_next    = frac_bot_reg[W-1] ? alu_diff[W-1:0] : frac_bot_reg;
                gy_next    = mb_next;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                k_next = '0;
                if (gx_reg == '0)
                begin
                    // Zero numerator: 0/b becomes 0/1, 0/0 holds.
                    if (gy_reg != '0)
                    begin
                        frac_bot_next = W'(1);
                    end
                    state_next = S_DONE;
                end
                else if (gy_reg == '0)
                begin
                    d_next      = gx_reg;
                    q_next      = mt_reg;
                    rem_next    = '0;
                    cnt_next    = '0;
                    second_next = 1'b0;
                    state_next  = S_DIV;
                end
                else
                begin
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                if (gx_reg == '0)
                begin
                    d_next      = gy_reg << k_reg;
                    q_next      = mt_reg;
                    rem_next    = '0;
                    cnt_next    = '0;
                    second_next = 1'b0;
                    state_next  = S_DIV;
                end
                else if (!gx_reg[0] && !gy_reg[0])
                begin
                    gx_next = gx_reg >> 1;
                    gy_next = gy_reg >> 1;
                    k_next  = k_reg + rmr_pkg::CNT_W'(1);
                end
                else if (!gx_reg[0])
                begin
                    gx_next = gx_reg >> 1;
                end
                else if (!gy_reg[0])
                begin
                    gy_next = gy_reg >> 1;
                end
                else if (!alu_borrow)
                begin
                    // Both odd: the difference is even, halve it at once.
                    gx_next = {1'b0, alu_diff[W-1:1]};
                end
                else
                begin
                    gx_next = gy_reg;
                    gy_next = gx_reg;
                end
            end
            S_DIV:
            begin
                if (!alu_borrow)
                begin
                    rem_next = alu_diff[W-1:0];
                    q_next   = {q_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[W-2:0], q_reg[W-1]};
                    q_next   = {q_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + rmr_pkg::CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_NEG;
                end
            end
            S_NEG:
            begin
                if (!second_reg)
                begin
                    frac_top_next = neg_result;
                    q_next        = mb_reg;
                    rem_next      = '0;
                    cnt_next      = '0;
                    second_next   = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    frac_bot_next = neg_result;
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                // Wait for the output register to free up.
                if (!out_valid_reg || !out_stall)
                begin
                    out_top_next    = rmr_pkg::IO_W'(frac_top_reg);
                    out_bot_next    = rmr_pkg::IO_W'(frac_bot_reg);
                    out_status_next = status_reg;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            frac_top_reg  <= '0;
            frac_bot_reg  <= W'(1);
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            k_reg         <= '0;
            second_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            frac_top_reg  <= frac_top_next;
            frac_bot_reg  <= frac_bot_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            second_reg    <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opt_reg        <= opt_next;
        opb_reg        <= opb_next;
        prod_reg       <= prod_next;
        mt_reg         <= mt_next;
        mb_reg         <= mb_next;
        gx_reg         <= gx_next;
        gy_reg         <= gy_next;
        d_reg          <= d_next;
        rem_reg        <= rem_next;
        q_reg          <= q_next;
        status_reg     <= status_next;
        out_top_reg    <= out_top_next;
        out_bot_reg    <= out_bot_next;
        out_status_reg <= out_status_next;
    end

endmodule

FILE: hw/rtl/rmr_checker.sv
// Port-level checks for the rational multiply/reduce block, bound to the top level.
`timescale 1ns / 1ps

module rmr_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic [1:0]                       op,
    input logic signed [rmr_pkg::IO_W-1:0]  operand_top,
    input logic signed [rmr_pkg::IO_W-1:0]  operand_bottom,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic signed [rmr_pkg::IO_W-1:0]  value_top,
    input logic signed [rmr_pkg::IO_W-1:0]  value_bottom,
    input logic [1:0]                       status
);

    // Block goes busy right after taking an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after an accepted item");

    // A new result appears together with the block going idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("result presented while still busy");

    // Status carries only defined codes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == rmr_pkg::STATUS_OK) ||
                      (status == rmr_pkg::STATUS_ZERO_DEN) ||
                      (status == rmr_pkg::STATUS_OVERFLOW))
        else $error("undefined status code");

    // Hold a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value_top) &&
                                   $stable(value_bottom) && $stable(status))
        else $error("stalled result changed");

endmodule

bind rational_multiply_reduce_core rmr_checker u_rmr_checker (.*);

FILE: verif/tb.sv
// Testbench for rational_multiply_reduce_core with a fraction predictor.
`timescale 1ns / 1ps

module tb;

    localparam int W = rmr_pkg::WIDTH;
    localparam int IO_W = rmr_pkg::IO_W;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int N_RANDOM = 555;
    localparam int DRAIN_AT = 150;
    localparam int HOLD_AT = 470;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 300;
    localparam longint F_MAX = (longint'(1) <<< (W - 1)) - 1;
    localparam longint F_MIN = -(longint'(1) <<< (W - 1));
    localparam logic signed [IO_W-1:0] OPND_MAX = 32'sh7fffffff;
    localparam logic signed [IO_W-1:0] OPND_MIN = -32'sh7fffffff;

    typedef struct packed {
        logic [1:0]              op;
        logic signed [IO_W-1:0]  top;
        logic signed [IO_W-1:0]  bottom;
        logic                    drain;
    } item_t;

    typedef struct packed {
        logic signed [IO_W-1:0]  top;
        logic signed [IO_W-1:0]  bottom;
        logic [1:0]              status;
    } frac_res_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [1:0]              op = rmr_pkg::OP_LOAD;
    logic signed [IO_W-1:0]  operand_top = '0;
    logic signed [IO_W-1:0]  operand_bottom = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [IO_W-1:0]  value_top;
    logic signed [IO_W-1:0]  value_bottom;
    logic [1:0]              status;

    item_t        pending[$];
    frac_res_t    expected_fracs[$];
    item_t        cur;
    int           n_total = 1;
    int           n_accepted = 0;
    int           errors = 0;
    int           hold_cnt = 0;
    bit           hold_done = 1'b0;
    int           idle_cycles = 0;

    logic signed [W-1:0] frac_top = '0;
    logic signed [W-1:0] frac_bottom = 1;

    rational_multiply_reduce_core i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .operand_top    (operand_top),
        .operand_bottom (operand_bottom),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .value_top      (value_top),
        .value_bottom   (value_bottom),
        .status         (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [W-1:0] mul_wrap(input logic signed [W-1:0] a,
                                                      input logic signed [IO_W-1:0] b,
                                                      inout bit ovf);
        longint p;
        p = longint'(a) * longint'(b);
        if (p > F_MAX || p < F_MIN)
            ovf = 1'b1;
        return W'(p);
    endfunction

    // Apply one item to the predicted fraction and return the result it should produce.
    function automatic frac_res_t step_fraction(input item_t it);
        frac_res_t res;
        bit        ovf;
        longint    mt;
        longint    mb;
        longint    x;
        longint    y;
        longint    r;
        ovf = 1'b0;
        res.status = rmr_pkg::STATUS_OK;
        case (it.op)
            rmr_pkg::OP_LOAD:
            begin
                if (it.bottom[W-1:0] == '0)
                    res.status = rmr_pkg::STATUS_ZERO_DEN;
                else
                begin
                    frac_top = it.top[W-1:0];
                    frac_bottom = it.bottom[W-1:0];
                end
            end
            rmr_pkg::OP_MUL:
            begin
                frac_top = mul_wrap(frac_top, it.top, ovf);
                frac_bottom = mul_wrap(frac_bottom, it.bottom, ovf);
                if (ovf)
                    res.status = rmr_pkg::STATUS_OVERFLOW;
            end
            rmr_pkg::OP_REDUCE:
            begin
                mt = longint'(frac_top);
                mb = longint'(frac_bottom);
                if (mt < 0)
                    mt = -mt;
                if (mb < 0)
                    mb = -mb;
                if (mt == 0)
                begin
                    if (mb != 0)
                        frac_bottom = 1;
                end
                else
                begin
                    x = mt;
                    y = mb;
                    while (y != 0)
                    begin
                        r = x % y;
                        x = y;
                        y = r;
                    end
                    // Division truncates toward zero, so each sign stays put.
                    frac_top = W'(longint'(frac_top) / x);
                    frac_bottom = W'(longint'(frac_bottom) / x);
                end
            end
            default:
            begin
            end
        endcase
        res.top = IO_W'(frac_top);
        res.bottom = IO_W'(frac_bottom);
        return res;
    endfunction

    function automatic logic signed [IO_W-1:0] pick_operand(input bit nonzero);
        logic signed [IO_W-1:0] v;
        int unsigned            kind;
        kind = $urandom_range(99);
        if (kind < 5)
            v = '0;
        else if (kind < 40)
            v = $urandom_range(16, 1);
        else if (kind < 65)
            v = $urandom_range(5000, 1);
        else if (kind < 80)
            v = 32'sd1 <<< $urandom_range(30, 0);
        else
            v = $urandom;
        if (kind < 80 && $urandom_range(1) == 1)
            v = -v;
        // Keep inside the operand range.
        if (v == {1'b1, {(IO_W-1){1'b0}}})
            v = v + 1;
        if (nonzero && v == '0)
            v = 1;
        return v;
    endfunction

    task automatic add_item(input logic [1:0] o, input logic signed [IO_W-1:0] t,
                            input logic signed [IO_W-1:0] b, input bit drain);
        item_t it;
        it.op = o;
        it.top = t;
        it.bottom = b;
        it.drain = drain;
        pending.push_back(it);
    endtask

    function automatic int sender_idle_pct();
        case (n_accepted * 3 / n_total)
            0: return 34;
            1: return 49;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_idle_pct();
        case (n_accepted * 3 / n_total)
            0: return 49;
            1: return 34;
            default: return 0;
        endcase
    endfunction

    // Driver: hold an offered item until it is taken, then offer the next one.
    always @(posedge clk)
    begin
        item_t nxt;
        bit    take;
        if (rst_n)
        begin
            take = in_valid && !in_stall;
            if (take)
            begin
                expected_fracs.push_back(step_fraction(cur));
                n_accepted <= n_accepted + 1;
            end
            if (!in_valid || take)
            begin
                if (pending.size() > 0 && !(pending[0].drain && expected_fracs.size() > 0)
                    && $urandom_range(99) >= sender_idle_pct())
                begin
                    nxt = pending.pop_front();
                    cur <= nxt;
                    in_valid <= 1'b1;
                    op <= nxt.op;
                    operand_top <= nxt.top;
                    operand_bottom <= nxt.bottom;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input logic signed [IO_W-1:0] want,
                               input logic signed [IO_W-1:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // Monitor: compare each result with the oldest expectation and drive out_stall.
    always @(posedge clk)
    begin
        frac_res_t want;
        bit        hold;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_fracs.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none actual %0d/%0d status %0d",
                             $time, value_top, value_bottom, status);
                end
                else
                begin
                    want = expected_fracs.pop_front();
                    check_field("value_top", want.top, value_top);
                    check_field("value_bottom", want.bottom, value_bottom);
                    check_field("status", IO_W'(want.status), IO_W'(status));
                end
            end
            hold = 1'b0;
            if (hold_cnt > 0)
            begin
                hold = 1'b1;
                hold_cnt <= hold_cnt - 1;
            end
            else if (!hold_done && n_accepted >= HOLD_AT)
            begin
                // Long hold-off: let the block fill up and stall its input.
                hold = 1'b1;
                hold_cnt <= HOLD_CYCLES - 1;
                hold_done <= 1'b1;
            end
            out_stall <= hold || ($urandom_range(99) < receiver_idle_pct());
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int          n_real;
        int unsigned sel;
        bit          drain;

        // Directed part.
        add_item(rmr_pkg::OP_REDUCE, 0, 0, 1'b0);       // zero numerator after reset
        add_item(rmr_pkg::OP_LOAD, 0, 5, 1'b0);
        add_item(rmr_pkg::OP_REDUCE, 0, 0, 1'b0);
        add_item(rmr_pkg::OP_LOAD, 7, 0, 1'b0);         // zero denominator rejected
        add_item(OP_UNUSED, OPND_MIN, OPND_MAX, 1'b0);
        add_item(rmr_pkg::OP_LOAD, OPND_MAX, OPND_MIN, 1'b0);
        add_item(rmr_pkg::OP_REDUCE, 0, 0, 1'b0);
        add_item(rmr_pkg::OP_LOAD, OPND_MIN, OPND_MAX, 1'b0);
        add_item(rmr_pkg::OP_REDUCE, -1, -1, 1'b0);
        add_item(rmr_pkg::OP_LOAD, 12, -18, 1'b0);
        add_item(rmr_pkg::OP_REDUCE, 0, 0, 1'b0);
        add_item(rmr_pkg::OP_MUL, -4, 6, 1'b0);
        add_item(rmr_pkg::OP_REDUCE, 0, 0, 1'b0);
        add_item(rmr_pkg::OP_LOAD, 65536, 65536, 1'b0);
        add_item(rmr_pkg::OP_MUL, 32768, 65536, 1'b0);  // both products overflow
        add_item(rmr_pkg::OP_LOAD, -65536, 1, 1'b0);
        add_item(rmr_pkg::OP_MUL, 32768, 1, 1'b0);      // exactly the most negative value
        add_item(rmr_pkg::OP_REDUCE, 0, 0, 1'b0);
        add_item(rmr_pkg::OP_MUL, OPND_MAX, OPND_MIN, 1'b0);
        add_item(rmr_pkg::OP_LOAD, 3, 4, 1'b0);
        add_item(rmr_pkg::OP_MUL, 5, 0, 1'b0);          // denominator becomes zero
        add_item(rmr_pkg::OP_REDUCE, 0, 0, 1'b0);
        add_item(rmr_pkg::OP_LOAD, 0, 1, 1'b0);
        add_item(rmr_pkg::OP_MUL, 1, 0, 1'b0);
        add_item(rmr_pkg::OP_REDUCE, 0, 0, 1'b0);       // zero over zero stays
        add_item(rmr_pkg::OP_LOAD, -6, -4, 1'b0);
        add_item(rmr_pkg::OP_REDUCE, 0, 0, 1'b0);

        // Random part: loads, multiply chains, reductions and the unused op.
        n_real = 0;
        while (n_real < N_RANDOM)
        begin
            sel = $urandom_range(99);
            drain = (n_real == DRAIN_AT);
            if (sel < 25)
                add_item(rmr_pkg::OP_LOAD, pick_operand(1'b0),
                         ($urandom_range(99) < 6) ? '0 : pick_operand(1'b1), drain);
            else if (sel < 60)
                add_item(rmr_pkg::OP_MUL, pick_operand(1'b0),
                         ($urandom_range(99) < 2) ? '0 : pick_operand(1'b1), drain);
            else if (sel < 97)
                add_item(rmr_pkg::OP_REDUCE, $urandom, $urandom, drain);
            else
                add_item(OP_UNUSED, $urandom, $urandom, 1'b0);
            if (sel < 97)
                n_real++;
        end
        n_total = pending.size();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending.size() != 0 || in_valid || expected_fracs.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_fracs.size() != 0)
        begin
            errors++;
            $display("%0t: %0d results still expected, expected 0 actual %0d outstanding",
                     $time, expected_fracs.size(), expected_fracs.size());
        end
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/rmr_pkg.sv
hw/rtl/rational_multiply_reduce_core.sv
hw/rtl/rmr_checker.sv
verif/tb.sv
